// File: hdl/s2d_pkg.sv
package s2d_pkg;

  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 6;
  localparam int LEN_W   = 4;
  localparam int DIGIT_W = 4;
  localparam int RADIX   = 10;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

  typedef struct packed {
    logic clr;
    logic dabble;
    logic rotate;
  } s2d_ctl_t;

  function automatic int digits_for(int bits);
    longint unsigned mag;
    longint unsigned p;
    int n;
    mag = 64'd1 << (bits - 1);
    p   = 64'(RADIX);
    n   = 1;
    for (int i = 0; i < 20; i++) begin
      if (p <= mag) begin
        n++;
        p = p * 64'(RADIX);
      end
    end
    return n;
  endfunction

endpackage

// File: hdl/s2d_in_if.sv
interface s2d_in_if import s2d_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: hdl/s2d_out_if.sv
interface s2d_out_if import s2d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic [LEN_W-1:0]  text_length;
  logic              last;

  modport source (output valid, output char_code, output text_length, output last,
                  input ready);
  modport sink   (input valid, input char_code, input text_length, input last,
                  output ready);
endinterface

// File: hdl/s2d_cell.sv
module s2d_cell import s2d_pkg::*; (
  input  logic               clk,
  input  s2d_ctl_t           ctl,
  input  logic               bit_in,
  input  logic [DIGIT_W-1:0] dig_in,
  output logic               bit_out,
  output logic [DIGIT_W-1:0] digit
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // add 3 before the shift when the digit would pass 9
  assign adj     = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out = adj[DIGIT_W-1];
  assign digit   = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clr) begin
      digit_nxt = '0;
    end else if (ctl.dabble) begin
      digit_nxt = {adj[DIGIT_W-2:0], bit_in};
    end else if (ctl.rotate) begin
      digit_nxt = dig_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// File: hdl/signed_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
//
// in_ch carries one two's-complement value per word; the low VALUE_BITS bits
// are used. out_ch returns the text one character per word, most significant
// character first, with a leading '-' for negative values, no leading zeros
// and '0' for zero. Each word carries text_length (whole text, sign included)
// and last on the final character.
//
// After a word is accepted, a row of BCD digit cells takes one magnitude bit
// per cycle (double dabble), then leading zero digits are dropped at one per
// cycle, then one character leaves per cycle while out_ch is not stalled.
// in_ch is ready only between items. The output register holds a character
// while out_ch is stalled and the row of cells waits with it; the next value
// is accepted as soon as the final character sits in the output register.
// Reset returns the block to idle and drops any word in flight.
module signed_to_decimal_ascii import s2d_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  s2d_in_if.sink          in_ch,
  s2d_out_if.source       out_ch
);

  localparam int ND = digits_for(VALUE_BITS);
  localparam int RW = $clog2(ND + 1);
  localparam int BW = $clog2(VALUE_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_TRIM = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [BW-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  sign_pend_r, sign_pend_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     char_r, char_nxt;
  logic [LEN_W-1:0]      olen_r, olen_nxt;
  logic                  last_r, last_nxt;

  logic [VALUE_BITS-1:0] raw;
  logic                  raw_neg;
  logic                  accept;
  logic                  out_free;
  logic [RW:0]           len_full;
  s2d_ctl_t              ctl;

  logic [ND-1:0]         carry;
  logic [DIGIT_W-1:0]    dig [ND];
  logic [DIGIT_W-1:0]    top_dig;

  generate
    if (VALUE_BITS <= VALUE_W) begin : g_narrow
      assign raw = in_ch.value[VALUE_BITS-1:0];
    end else begin : g_wide
      assign raw = {{(VALUE_BITS - VALUE_W){1'b0}}, in_ch.value};
    end
  endgenerate

  assign raw_neg     = raw[VALUE_BITS-1];
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign top_dig     = dig[ND-1];
  assign len_full    = {1'b0, rem_r} + (RW + 1)'(neg_r);

  genvar gi;
  generate
    for (gi = 0; gi < ND; gi++) begin : g_cell
      s2d_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  ((gi == 0) ? mag_r[VALUE_BITS-1] : carry[(gi == 0) ? 0 : gi - 1]),
        .dig_in  ((gi == 0) ? {DIGIT_W{1'b0}} : dig[(gi == 0) ? 0 : gi - 1]),
        .bit_out (carry[gi]),
        .digit   (dig[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    rem_nxt       = rem_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    char_nxt      = char_r;
    olen_nxt      = olen_r;
    last_nxt      = last_r;
    ctl           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mag_nxt       = raw_neg ? (~raw + 1'b1) : raw;
          neg_nxt       = raw_neg;
          sign_pend_nxt = raw_neg;
          bit_cnt_nxt   = '0;
          rem_nxt       = RW'(ND);
          ctl.clr       = 1'b1;
          state_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble  = 1'b1;
        mag_nxt     = mag_r << 1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BW'(VALUE_BITS - 1)) begin
          state_nxt = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if ((top_dig == '0) && (rem_r > RW'(1))) begin
          ctl.rotate = 1'b1;
          rem_nxt    = rem_r - 1'b1;
        end else begin
          len_nxt   = LEN_W'(len_full);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          olen_nxt      = len_r;
          if (sign_pend_r) begin
            char_nxt      = CH_MINUS;
            last_nxt      = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            char_nxt   = CH_ZERO + CHAR_W'(top_dig);
            last_nxt   = (rem_r == RW'(1));
            ctl.rotate = 1'b1;
            rem_nxt    = rem_r - 1'b1;
            if (rem_r == RW'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      bit_cnt_r   <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    len_r  <= len_nxt;
    char_r <= char_nxt;
    olen_r <= olen_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.char_code   = char_r;
  assign out_ch.text_length = olen_r;
  assign out_ch.last        = last_r;

  a_no_top_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> !carry[ND-1])
    else $error("digit row overflow");

  a_conv_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |=> (state_r == ST_CONV) || (state_r == ST_TRIM))
    else $error("conversion left early");

  a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (rem_r != '0))
    else $error("emit with no digits left");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.char_code == CH_MINUS)) |-> !out_ch.last)
    else $error("sign marked as last character");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_CONV) && (bit_cnt_r == '0))
    else $error("conversion did not start");

endmodule
